[sv/pmr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pmr_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int SRC_DEPTH   = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CAP_16      = 16;

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_REINDEX = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NEW   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  slot;
        logic [15:0] color;
        logic [7:0]  pixel_in;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  pixel_out;
        logic [7:0]  merged_index;
        logic [15:0] color_out;
        logic [8:0]  merged_count;
        logic [1:0]  status;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LD_KEY,
        S_SRC_RD,
        S_SRC_KEY,
        S_SCAN,
        S_LOOKUP_END,
        S_MREAD,
        S_MREAD_END,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_LD_KEY,
        DP_SRC_READ,
        DP_SRC_KEY,
        DP_SCAN,
        DP_LOAD_END,
        DP_PIX_END,
        DP_MREAD,
        DP_MREAD_END,
        DP_PUBLISH
    } t_dp_op;

    typedef enum logic [1:0] {
        NIB_FULL,
        NIB_HI,
        NIB_LO
    } t_nib;

    typedef struct packed {
        t_dp_op op;
        t_nib   nib;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       mode;
        logic       hit;
        logic       miss;
    } t_dp_status;

endpackage

`default_nettype wire

[sv/pmr_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module pmr_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    input  wire pmr_pkg::t_in_beat  i_in_beat,
    input  wire pmr_pkg::t_dp_cmd   i_cmd,
    output pmr_pkg::t_dp_status     o_status,
    output pmr_pkg::t_out_beat      o_out_beat
);

    logic [15:0]                    r_merged_mem [pmr_pkg::TABLE_DEPTH];
    logic [15:0]                    r_src_mem    [pmr_pkg::SRC_DEPTH];
    logic [pmr_pkg::SRC_DEPTH-1:0]  r_src_vld;

    pmr_pkg::t_in_beat              r_item;
    pmr_pkg::t_out_beat             r_out;
    logic [pmr_pkg::CNT_W-1:0]      r_count;
    logic                           r_mode;
    logic [15:0]                    r_key;
    logic [pmr_pkg::CNT_W-1:0]      r_scan_addr;
    logic [pmr_pkg::IDX_W-1:0]      r_tag;
    logic                           r_tag_vld;
    logic                           r_found;
    logic [pmr_pkg::IDX_W-1:0]      r_fidx;
    logic                           r_mr_ok;
    logic [15:0]                    r_m_rd;
    logic [15:0]                    r_s_rd;
    logic                           r_s_rd_vld;
    logic [7:0]                     r_pix;
    logic [7:0]                     r_midx;
    logic [15:0]                    r_cout;
    logic [1:0]                     r_stat;

    logic [pmr_pkg::IDX_W-1:0]      m_addr;
    logic                           m_we;
    logic [7:0]                     s_addr;
    logic [pmr_pkg::CNT_W-1:0]      cap;
    logic                           can_add;
    logic                           scan_more;
    logic                           hit;
    logic                           miss;
    logic                           small_idx;

    assign cap       = r_mode ? pmr_pkg::CNT_W'(pmr_pkg::TABLE_DEPTH)
                              : pmr_pkg::CNT_W'(pmr_pkg::CAP_16);
    assign can_add   = r_count < cap;
    assign scan_more = r_scan_addr < r_count;
    assign hit       = r_tag_vld && (r_m_rd == r_key);
    assign miss      = !r_tag_vld && !scan_more;
    assign small_idx = r_fidx <= pmr_pkg::IDX_W'(15);
    assign m_we      = (i_cmd.op == pmr_pkg::DP_LOAD_END) && !r_found && can_add;

    always_comb begin
        if (i_cmd.op == pmr_pkg::DP_SCAN) begin
            m_addr = r_scan_addr[pmr_pkg::IDX_W-1:0];
        end else begin
            m_addr = r_item.slot[pmr_pkg::IDX_W-1:0];
        end
    end

    always_comb begin
        if (i_cmd.op == pmr_pkg::DP_SRC_READ) begin
            case (i_cmd.nib)
                pmr_pkg::NIB_HI: s_addr = {4'd0, r_item.pixel_in[7:4]};
                pmr_pkg::NIB_LO: s_addr = {4'd0, r_item.pixel_in[3:0]};
                default:         s_addr = r_item.pixel_in;
            endcase
        end else begin
            s_addr = r_item.slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_merged_mem[r_count[pmr_pkg::IDX_W-1:0]] <= r_key;
        end
        r_m_rd <= r_merged_mem[m_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pmr_pkg::DP_LD_KEY) begin
            r_src_mem[s_addr] <= r_item.color;
        end
        r_s_rd     <= r_src_mem[s_addr];
        r_s_rd_vld <= r_src_vld[s_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_vld <= '0;
            r_count   <= '0;
            r_mode    <= 1'b1;
            r_tag_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            case (i_cmd.op)
                pmr_pkg::DP_LD_KEY: begin
                    r_src_vld[s_addr] <= 1'b1;
                    r_tag_vld         <= 1'b0;
                end
                pmr_pkg::DP_SRC_KEY: begin
                    r_tag_vld <= 1'b0;
                end
                pmr_pkg::DP_SCAN: begin
                    r_tag_vld <= scan_more;
                end
                pmr_pkg::DP_LOAD_END: begin
                    if (m_we) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pmr_pkg::DP_CAPTURE: begin
                r_item <= i_in_beat;
                r_pix  <= '0;
                r_midx <= '0;
                r_cout <= '0;
                r_stat <= pmr_pkg::ST_OK;
            end
            pmr_pkg::DP_LD_KEY: begin
                r_key       <= r_item.color;
                r_scan_addr <= '0;
            end
            pmr_pkg::DP_SRC_KEY: begin
                r_key       <= r_s_rd_vld ? r_s_rd : 16'd0;
                r_scan_addr <= '0;
            end
            pmr_pkg::DP_SCAN: begin
                if (scan_more) begin
                    r_scan_addr <= r_scan_addr + 1'b1;
                    r_tag       <= r_scan_addr[pmr_pkg::IDX_W-1:0];
                end
                if (hit) begin
                    r_found <= 1'b1;
                    r_fidx  <= r_tag;
                end else if (miss) begin
                    r_found <= 1'b0;
                end
            end
            pmr_pkg::DP_LOAD_END: begin
                if (r_found) begin
                    r_midx <= 8'(r_fidx);
                    r_stat <= pmr_pkg::ST_OK;
                end else if (can_add) begin
                    r_midx <= r_count[7:0];
                    r_stat <= pmr_pkg::ST_NEW;
                end else begin
                    r_stat <= pmr_pkg::ST_FULL;
                end
            end
            pmr_pkg::DP_PIX_END: begin
                case (i_cmd.nib)
                    pmr_pkg::NIB_HI: begin
                        if (r_found && small_idx) begin
                            r_pix[7:4] <= r_fidx[3:0];
                        end else begin
                            r_stat <= pmr_pkg::ST_MISS;
                        end
                    end
                    pmr_pkg::NIB_LO: begin
                        if (r_found && small_idx) begin
                            r_pix[3:0] <= r_fidx[3:0];
                        end else begin
                            r_stat <= pmr_pkg::ST_MISS;
                        end
                    end
                    default: begin
                        if (r_found) begin
                            r_pix <= 8'(r_fidx);
                        end else begin
                            r_stat <= pmr_pkg::ST_MISS;
                        end
                    end
                endcase
            end
            pmr_pkg::DP_MREAD: begin
                r_mr_ok <= pmr_pkg::CNT_W'(r_item.slot) < r_count;
            end
            pmr_pkg::DP_MREAD_END: begin
                r_cout <= r_mr_ok ? r_m_rd : 16'd0;
            end
            pmr_pkg::DP_PUBLISH: begin
                r_out.pixel_out    <= r_pix;
                r_out.merged_index <= r_midx;
                r_out.color_out    <= r_cout;
                r_out.merged_count <= 9'(r_count);
                r_out.status       <= r_stat;
            end
            default: begin
            end
        endcase
    end

    assign o_status.action = r_item.action;
    assign o_status.mode   = r_mode;
    assign o_status.hit    = hit;
    assign o_status.miss   = miss;
    assign o_out_beat      = r_out;

endmodule

`default_nettype wire

[sv/pmr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module pmr_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_out_stall,
    input  wire pmr_pkg::t_dp_status i_status,
    output pmr_pkg::t_dp_cmd         o_cmd,
    output logic                     o_in_stall,
    output logic                     o_out_valid
);

    pmr_pkg::t_state r_state;
    pmr_pkg::t_state n_state;
    pmr_pkg::t_nib   r_nib;
    pmr_pkg::t_nib   n_nib;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmr_pkg::S_IDLE;
            r_nib       <= pmr_pkg::NIB_FULL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nib       <= n_nib;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_nib       = r_nib;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            pmr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pmr_pkg::S_DISPATCH;
                end
            end
            pmr_pkg::S_DISPATCH: begin
                case (i_status.action)
                    pmr_pkg::ACT_LOAD: begin
                        n_state = pmr_pkg::S_LD_KEY;
                    end
                    pmr_pkg::ACT_REINDEX: begin
                        n_state = pmr_pkg::S_SRC_RD;
                        n_nib   = i_status.mode ? pmr_pkg::NIB_FULL : pmr_pkg::NIB_HI;
                    end
                    pmr_pkg::ACT_READ: begin
                        n_state = pmr_pkg::S_MREAD;
                    end
                    default: begin
                        n_state = pmr_pkg::S_DONE;
                    end
                endcase
            end
            pmr_pkg::S_LD_KEY:  n_state = pmr_pkg::S_SCAN;
            pmr_pkg::S_SRC_RD:  n_state = pmr_pkg::S_SRC_KEY;
            pmr_pkg::S_SRC_KEY: n_state = pmr_pkg::S_SCAN;
            pmr_pkg::S_SCAN: begin
                if (i_status.hit || i_status.miss) begin
                    n_state = pmr_pkg::S_LOOKUP_END;
                end
            end
            pmr_pkg::S_LOOKUP_END: begin
                if (i_status.action == pmr_pkg::ACT_REINDEX && r_nib == pmr_pkg::NIB_HI) begin
                    n_state = pmr_pkg::S_SRC_RD;
                    n_nib   = pmr_pkg::NIB_LO;
                end else begin
                    n_state = pmr_pkg::S_DONE;
                end
            end
            pmr_pkg::S_MREAD:     n_state = pmr_pkg::S_MREAD_END;
            pmr_pkg::S_MREAD_END: n_state = pmr_pkg::S_DONE;
            pmr_pkg::S_DONE: begin
                if (out_free) begin
                    n_state     = pmr_pkg::S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = pmr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.op  = pmr_pkg::DP_NOP;
        o_cmd.nib = r_nib;
        case (r_state)
            pmr_pkg::S_LD_KEY:    o_cmd.op = pmr_pkg::DP_LD_KEY;
            pmr_pkg::S_SRC_RD:    o_cmd.op = pmr_pkg::DP_SRC_READ;
            pmr_pkg::S_SRC_KEY:   o_cmd.op = pmr_pkg::DP_SRC_KEY;
            pmr_pkg::S_SCAN:      o_cmd.op = pmr_pkg::DP_SCAN;
            pmr_pkg::S_LOOKUP_END: begin
                if (i_status.action == pmr_pkg::ACT_LOAD) begin
                    o_cmd.op = pmr_pkg::DP_LOAD_END;
                end else begin
                    o_cmd.op = pmr_pkg::DP_PIX_END;
                end
            end
            pmr_pkg::S_MREAD:     o_cmd.op = pmr_pkg::DP_MREAD;
            pmr_pkg::S_MREAD_END: o_cmd.op = pmr_pkg::DP_MREAD_END;
            pmr_pkg::S_DONE: begin
                if (out_free) begin
                    o_cmd.op = pmr_pkg::DP_PUBLISH;
                end
            end
            default: begin
                o_cmd.op = pmr_pkg::DP_NOP;
            end
        endcase
    end

    assign o_in_stall  = r_state != pmr_pkg::S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[sv/palette_merge_reindex.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_stall  i_in_beat  (pmr_pkg::t_in_beat)
// out       output     o_out_valid / i_out_stall o_out_beat (pmr_pkg::t_out_beat)
// cfg       input      i_cfg_we                 i_cfg_wdata (mode_256)
//
// One item is handled at a time. A lookup scans the merged table one entry a cycle
// through its single read port. A load and a 256-colour reindex each do one lookup,
// a 16-colour reindex does two, one per nibble, and a read beat reads its slot
// directly without a scan.
// Reset clears the count and the source valid bits at once.
// A finished beat waits in the output register while the next item is accepted.

module palette_merge_reindex (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire pmr_pkg::t_in_beat  i_in_beat,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output pmr_pkg::t_out_beat      o_out_beat,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata
);

    pmr_pkg::t_dp_cmd    ctrl_cmd;
    pmr_pkg::t_dp_cmd    dp_cmd;
    pmr_pkg::t_dp_status dp_status;
    logic                accept;

    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        dp_cmd = ctrl_cmd;
        if (accept) begin
            dp_cmd.op = pmr_pkg::DP_CAPTURE;
        end
    end

    pmr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (ctrl_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    pmr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_beat   (i_in_beat),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_beat  (o_out_beat)
    );

endmodule

`default_nettype wire
